// File: design/pafsm_pkg.sv
// Package for the partition allocator: codes, cell control struct and sizing defaults.
// Used by pafsm_cell and partition_allocator_fit_split_merge; depends on nothing.
`default_nettype none
package pafsm_pkg;
    localparam int DEF_MAX_PARTITIONS = 32;
    localparam int DEF_ADDR_BITS      = 24;
    localparam int DEF_ID_BITS        = 8;

    // item function codes; the last one is unused and dropped without a result
    localparam logic [1:0] FN_APPEND  = 2'd0;
    localparam logic [1:0] FN_CREATE  = 2'd1;
    localparam logic [1:0] FN_DESTROY = 2'd2;
    localparam logic [1:0] FN_NONE    = 2'd3;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_ID_EXISTS = 3'd1;
    localparam logic [2:0] ST_NO_FIT    = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    // fit policy codes; the last one never finds a partition
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;
    localparam logic [1:0] FIT_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_FIT_POLICY = 2'd0;
    localparam logic [1:0] CFG_DYNAMIC    = 2'd1;

    typedef enum logic [2:0] {
        C_HOLD,
        C_ROTATE,
        C_APPEND,
        C_GRANT,
        C_FREE_R,
        C_FREE_L
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     flag;
    } t_cell_ctl;
endpackage
`default_nettype wire

// File: design/partition_allocator_fit_split_merge.sv
// Top level of the partition allocator: sequencer, scanner and the row of table cells.
// Depends on pafsm_pkg and pafsm_cell.
//
// Usage: an item (func, owner_id, request_size) is taken at a rising edge with
// i_start high and o_busy low. Each item with a valid func gives one result on
// o_status, o_granted_base, o_granted_index and o_partition_size, shown for one
// cycle with o_valid high; the receiver cannot stall. Func code 3 is dropped.
// Append answers in the cycle after it is taken. Create and destroy rotate the
// whole row of MAX_PARTITIONS cells past the head cell once in S_SCAN, then
// apply the grant or free in S_APPLY, which registers the result. A destroy that
// merges with its left neighbor stays busy through S_LEFT for the second shift.
// Configuration: i_cfg_valid with i_cfg_index / i_cfg_data, always ready; write
// only while o_busy is low. Reset (synchronous, active low) empties the table,
// clears the running end address and sets first fit, fixed partitions.
`default_nettype none
module partition_allocator_fit_split_merge #(
    parameter int MAX_PARTITIONS = pafsm_pkg::DEF_MAX_PARTITIONS,
    parameter int ADDR_BITS      = pafsm_pkg::DEF_ADDR_BITS,
    parameter int ID_BITS        = pafsm_pkg::DEF_ID_BITS
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    output logic        o_busy,
    input  wire  [1:0]  i_func,
    input  wire  [7:0]  i_owner_id,
    input  wire  [23:0] i_request_size,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [23:0] o_granted_base,
    output logic [4:0]  o_granted_index,
    output logic [23:0] o_partition_size,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [1:0]  i_cfg_data
);
    import pafsm_pkg::*;

    localparam int N  = MAX_PARTITIONS;
    localparam int IW = $clog2(N);
    localparam int A  = ADDR_BITS;
    localparam int EW = 1 + ID_BITS + 2 * A;
    localparam logic [IW:0]   COUNT_MAX = (IW + 1)'(N);
    localparam logic [IW-1:0] LAST      = IW'(N - 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY, S_LEFT} t_state;

    t_state           r_state;
    logic [1:0]       r_policy;
    logic             r_dyn;
    logic [IW:0]      r_count;
    logic [A-1:0]     r_next_base;
    logic [1:0]       r_func;
    logic [ID_BITS-1:0] r_id;
    logic [A-1:0]     r_req;
    logic [IW-1:0]    r_j;
    logic             r_own_found, r_fit_found;
    logic [IW-1:0]    r_own_idx, r_fit_idx;
    logic [A-1:0]     r_own_base, r_own_size, r_fit_base, r_fit_size;
    logic             r_prev_busy, r_left_free, r_right_pend, r_right_free;
    logic [A-1:0]     r_prev_size, r_left_size, r_right_size, r_mid;

    logic [EW-1:0]    w_ent [N];
    t_cell_ctl        w_ctl;
    logic [IW:0]      w_idx;
    logic [A-1:0]     w_base, w_size, w_size2;

    logic             h_busy;
    logic [ID_BITS-1:0] h_owner;
    logic [A-1:0]     h_size, h_base;
    logic             w_valid_j, w_own_hit, w_fit_hit, w_split, w_merge_r;
    logic [A-1:0]     w_mid, w_left_sum;
    logic [A:0]       w_sum_r, w_sum_l;
    logic             w_take;

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_take      = i_start && !o_busy;

    // head cell as seen by the scanner
    assign {h_busy, h_owner, h_size, h_base} = w_ent[0];
    assign w_valid_j = {1'b0, r_j} < r_count;
    assign w_own_hit = w_valid_j && h_busy && h_owner == r_id && !r_own_found;
    assign w_fit_hit = w_valid_j && !h_busy && h_size >= r_req && r_policy != FIT_NONE;

    // split and merge arithmetic
    assign w_split   = r_dyn && r_fit_size != r_req && r_count < COUNT_MAX;
    assign w_merge_r = r_dyn && r_right_free;
    assign w_sum_r   = {1'b0, r_own_size} + {1'b0, r_right_size};
    assign w_mid     = w_merge_r ? (w_sum_r[A] ? {A{1'b1}} : w_sum_r[A-1:0]) : r_own_size;
    assign w_sum_l   = {1'b0, r_left_size} + {1'b0, r_mid};
    assign w_left_sum = w_sum_l[A] ? {A{1'b1}} : w_sum_l[A-1:0];

    // drive the broadcast command to the cells
    always_comb begin
        w_ctl   = '{op: C_HOLD, flag: 1'b0};
        w_idx   = {1'b0, r_own_idx};
        w_base  = r_fit_base + r_req;
        w_size  = r_fit_size - r_req;
        w_size2 = r_req;
        unique case (r_state)
            S_IDLE: begin
                w_idx  = r_count;
                w_base = r_next_base;
                w_size = A'(i_request_size);
                if (w_take && i_func == FN_APPEND && r_count < COUNT_MAX) begin
                    w_ctl.op = C_APPEND;
                end
            end
            S_SCAN: begin
                w_ctl.op = C_ROTATE;
            end
            S_APPLY: begin
                if (r_func == FN_CREATE) begin
                    w_idx = {1'b0, r_fit_idx};
                    if (!r_own_found && r_fit_found) begin
                        w_ctl = '{op: C_GRANT, flag: w_split};
                    end
                end else begin
                    w_size2 = w_mid;
                    if (r_own_found) begin
                        w_ctl = '{op: C_FREE_R, flag: w_merge_r};
                    end
                end
            end
            S_LEFT: begin
                w_size2  = w_left_sum;
                w_ctl.op = C_FREE_L;
            end
            default: begin
            end
        endcase
    end

    // row of cells; the top cell wraps to the head for rotation
    for (genvar g = 0; g < N; g++) begin : g_cell
        pafsm_cell #(
            .IDX(g), .IW(IW), .ADDR_BITS(A), .ID_BITS(ID_BITS), .EW(EW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_idx   (w_idx),
            .i_base  (w_base),
            .i_size  (w_size),
            .i_size2 (w_size2),
            .i_owner (r_id),
            .i_left  (w_ent[(g == 0) ? 0 : g - 1]),
            .i_right (w_ent[(g == N - 1) ? 0 : g + 1]),
            .o_entry (w_ent[g])
        );
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= FIT_FIRST;
            r_dyn    <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FIT_POLICY: r_policy <= i_cfg_data;
                CFG_DYNAMIC:    r_dyn    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // sequencer state and registered results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_next_base <= '0;
            o_valid     <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_take && i_func != FN_NONE) begin
                        r_func <= i_func;
                        r_id   <= ID_BITS'(i_owner_id);
                        r_req  <= A'(i_request_size);
                        r_j    <= '0;
                        r_own_found  <= 1'b0;
                        r_fit_found  <= 1'b0;
                        r_prev_busy  <= 1'b1;
                        r_right_pend <= 1'b0;
                        r_right_free <= 1'b0;
                        r_left_free  <= 1'b0;
                        if (i_func == FN_APPEND) begin
                            o_valid <= 1'b1;
                            if (r_count < COUNT_MAX) begin
                                r_count          <= r_count + 1'b1;
                                r_next_base      <= r_next_base + A'(i_request_size);
                                o_status         <= ST_OK;
                                o_granted_base   <= 24'(r_next_base);
                                o_granted_index  <= 5'(r_count);
                                o_partition_size <= 24'(A'(i_request_size));
                            end else begin
                                o_status         <= ST_FULL;
                                o_granted_base   <= '0;
                                o_granted_index  <= '0;
                                o_partition_size <= '0;
                            end
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_prev_busy <= h_busy;
                    r_prev_size <= h_size;
                    if (w_own_hit) begin
                        r_own_found  <= 1'b1;
                        r_own_idx    <= r_j;
                        r_own_base   <= h_base;
                        r_own_size   <= h_size;
                        r_left_free  <= (r_j != '0) && !r_prev_busy;
                        r_left_size  <= r_prev_size;
                        r_right_pend <= 1'b1;
                    end else begin
                        r_right_pend <= 1'b0;
                    end
                    if (r_right_pend) begin
                        r_right_free <= w_valid_j && !h_busy;
                        r_right_size <= h_size;
                    end
                    if (w_fit_hit && (!r_fit_found ||
                        (r_policy == FIT_BEST && h_size < r_fit_size) ||
                        (r_policy == FIT_WORST && h_size > r_fit_size))) begin
                        r_fit_found <= 1'b1;
                        r_fit_idx   <= r_j;
                        r_fit_size  <= h_size;
                        r_fit_base  <= h_base;
                    end
                    r_j <= r_j + 1'b1;
                    if (r_j == LAST) r_state <= S_APPLY;
                end
                S_APPLY: begin
                    o_valid          <= 1'b1;
                    o_status         <= ST_OK;
                    o_granted_base   <= '0;
                    o_granted_index  <= '0;
                    o_partition_size <= '0;
                    r_state          <= S_IDLE;
                    if (r_func == FN_CREATE) begin
                        if (r_own_found) begin
                            o_status <= ST_ID_EXISTS;
                        end else if (!r_fit_found) begin
                            o_status <= ST_NO_FIT;
                        end else begin
                            o_granted_base   <= 24'(r_fit_base);
                            o_granted_index  <= 5'(r_fit_idx);
                            o_partition_size <= 24'(w_split ? r_req : r_fit_size);
                            if (w_split) r_count <= r_count + 1'b1;
                        end
                    end else begin
                        if (!r_own_found) begin
                            o_status <= ST_NOT_FOUND;
                        end else begin
                            o_granted_base   <= 24'(r_own_base);
                            o_granted_index  <= 5'(r_own_idx);
                            o_partition_size <= 24'(r_own_size);
                            r_mid            <= w_mid;
                            if (w_merge_r) r_count <= r_count - 1'b1;
                            if (r_dyn && r_left_free) r_state <= S_LEFT;
                        end
                    end
                end
                S_LEFT: begin
                    r_count <= r_count - 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // the table never holds more entries than cells
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_MAX) else $error("entry count beyond table size");

    // failed items report zero fields
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |->
        (o_granted_base == '0 && o_granted_index == '0 && o_partition_size == '0))
        else $error("nonzero fields on failed item");

    // left merge only follows a destroy apply
    a_left_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEFT) |-> ($past(r_state) == S_APPLY && r_func == FN_DESTROY))
        else $error("left merge out of sequence");

    // a result comes out when the block leaves apply or answers an append
    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid || $past(r_state) == S_IDLE)
        else $error("result repeated");
endmodule
`default_nettype wire

// File: design/pafsm_cell.sv
// One table cell of the partition allocator: holds base, size, busy mark and owner.
// Depends on pafsm_pkg; neighbors feed it their entries for rotate and shift.
`default_nettype none
module pafsm_cell #(
    parameter int IDX       = 0,
    parameter int IW        = 5,
    parameter int ADDR_BITS = 24,
    parameter int ID_BITS   = 8,
    parameter int EW        = 1 + ID_BITS + 2 * ADDR_BITS
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire pafsm_pkg::t_cell_ctl i_ctl,
    input  wire  [IW:0]           i_idx,
    input  wire  [ADDR_BITS-1:0]  i_base,
    input  wire  [ADDR_BITS-1:0]  i_size,
    input  wire  [ADDR_BITS-1:0]  i_size2,
    input  wire  [ID_BITS-1:0]    i_owner,
    input  wire  [EW-1:0]         i_left,
    input  wire  [EW-1:0]         i_right,
    output logic [EW-1:0]         o_entry
);
    import pafsm_pkg::*;

    localparam logic [IW:0] MY = (IW + 1)'(IDX);

    logic                 r_busy, n_busy;
    logic [ID_BITS-1:0]   r_owner, n_owner;
    logic [ADDR_BITS-1:0] r_size, n_size;
    logic [ADDR_BITS-1:0] r_base, n_base;
    logic [IW:0]          w_idx1;

    assign w_idx1  = i_idx + 1'b1;
    assign o_entry = {r_busy, r_owner, r_size, r_base};

    // pick the next entry from the broadcast command and the neighbors
    always_comb begin
        {n_busy, n_owner, n_size, n_base} = o_entry;
        case (i_ctl.op)
            C_ROTATE: begin
                {n_busy, n_owner, n_size, n_base} = i_right;
            end
            C_APPEND: begin
                if (MY == i_idx) begin
                    {n_busy, n_owner, n_size, n_base} = {1'b0, ID_BITS'(0), i_size, i_base};
                end
            end
            C_GRANT: begin
                if (MY == i_idx) begin
                    n_busy  = 1'b1;
                    n_owner = i_owner;
                    if (i_ctl.flag) n_size = i_size2;
                end else if (i_ctl.flag && MY == w_idx1) begin
                    {n_busy, n_owner, n_size, n_base} = {1'b0, ID_BITS'(0), i_size, i_base};
                end else if (i_ctl.flag && MY > w_idx1) begin
                    {n_busy, n_owner, n_size, n_base} = i_left;
                end
            end
            C_FREE_R: begin
                if (MY == i_idx) begin
                    n_busy = 1'b0;
                    if (i_ctl.flag) n_size = i_size2;
                end else if (i_ctl.flag && MY > i_idx) begin
                    {n_busy, n_owner, n_size, n_base} = i_right;
                end
            end
            C_FREE_L: begin
                if (MY + 1'b1 == i_idx) begin
                    n_size = i_size2;
                end else if (MY >= i_idx) begin
                    {n_busy, n_owner, n_size, n_base} = i_right;
                end
            end
            default: begin
            end
        endcase
    end

    // clear the busy mark under reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    // advance payload
    always_ff @(posedge i_clk) begin
        r_owner <= n_owner;
        r_size  <= n_size;
        r_base  <= n_base;
    end
endmodule
`default_nettype wire
